// ----- rtl/dsha_pkg.sv -----
`timescale 1ns / 1ps

package dsha_pkg;

    localparam int unsigned WordW   = 32;
    localparam int unsigned NumH    = 8;
    localparam int unsigned NumW    = 16;
    localparam int unsigned NumRnd  = 64;
    localparam int unsigned RndW    = $clog2(NumRnd);

    localparam logic [WordW-1:0] PadWord   = 32'h8000_0000;
    localparam logic [WordW-1:0] LenHeader = 32'd640;
    localparam logic [WordW-1:0] LenDigest = 32'd256;

    typedef logic [WordW-1:0]            t_word;
    typedef logic [NumH-1:0][WordW-1:0]  t_hash;
    typedef logic [NumW-1:0][WordW-1:0]  t_block;
    typedef logic [RndW-1:0]             t_rnd;

    localparam t_hash InitH = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic t_word round_k(input t_rnd idx);
        case (idx)
            6'd0:  round_k = 32'h428A2F98;  6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hB5C0FBCF;  6'd3:  round_k = 32'hE9B5DBA5;
            6'd4:  round_k = 32'h3956C25B;  6'd5:  round_k = 32'h59F111F1;
            6'd6:  round_k = 32'h923F82A4;  6'd7:  round_k = 32'hAB1C5ED5;
            6'd8:  round_k = 32'hD807AA98;  6'd9:  round_k = 32'h12835B01;
            6'd10: round_k = 32'h243185BE;  6'd11: round_k = 32'h550C7DC3;
            6'd12: round_k = 32'h72BE5D74;  6'd13: round_k = 32'h80DEB1FE;
            6'd14: round_k = 32'h9BDC06A7;  6'd15: round_k = 32'hC19BF174;
            6'd16: round_k = 32'hE49B69C1;  6'd17: round_k = 32'hEFBE4786;
            6'd18: round_k = 32'h0FC19DC6;  6'd19: round_k = 32'h240CA1CC;
            6'd20: round_k = 32'h2DE92C6F;  6'd21: round_k = 32'h4A7484AA;
            6'd22: round_k = 32'h5CB0A9DC;  6'd23: round_k = 32'h76F988DA;
            6'd24: round_k = 32'h983E5152;  6'd25: round_k = 32'hA831C66D;
            6'd26: round_k = 32'hB00327C8;  6'd27: round_k = 32'hBF597FC7;
            6'd28: round_k = 32'hC6E00BF3;  6'd29: round_k = 32'hD5A79147;
            6'd30: round_k = 32'h06CA6351;  6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27B70A85;  6'd33: round_k = 32'h2E1B2138;
            6'd34: round_k = 32'h4D2C6DFC;  6'd35: round_k = 32'h53380D13;
            6'd36: round_k = 32'h650A7354;  6'd37: round_k = 32'h766A0ABB;
            6'd38: round_k = 32'h81C2C92E;  6'd39: round_k = 32'h92722C85;
            6'd40: round_k = 32'hA2BFE8A1;  6'd41: round_k = 32'hA81A664B;
            6'd42: round_k = 32'hC24B8B70;  6'd43: round_k = 32'hC76C51A3;
            6'd44: round_k = 32'hD192E819;  6'd45: round_k = 32'hD6990624;
            6'd46: round_k = 32'hF40E3585;  6'd47: round_k = 32'h106AA070;
            6'd48: round_k = 32'h19A4C116;  6'd49: round_k = 32'h1E376C08;
            6'd50: round_k = 32'h2748774C;  6'd51: round_k = 32'h34B0BCB5;
            6'd52: round_k = 32'h391C0CB3;  6'd53: round_k = 32'h4ED8AA4A;
            6'd54: round_k = 32'h5B9CCA4F;  6'd55: round_k = 32'h682E6FF3;
            6'd56: round_k = 32'h748F82EE;  6'd57: round_k = 32'h78A5636F;
            6'd58: round_k = 32'h84C87814;  6'd59: round_k = 32'h8CC70208;
            6'd60: round_k = 32'h90BEFFFA;  6'd61: round_k = 32'hA4506CEB;
            6'd62: round_k = 32'hBEF9A3F7;  6'd63: round_k = 32'hC67178F2;
            default: round_k = '0;
        endcase
    endfunction

endpackage

// ----- rtl/double_sha256_nonce_check_unit.sv -----
`timescale 1ns / 1ps
// Double SHA-256 nonce checker for an 80-byte header.
// Configure the midstate, the three tail words and the target through the
// write port while idle; each write lands at the clock edge where i_cfg_we is
// high. Indexes above six are ignored.
// Input channel: a nonce is taken when i_in_valid is high and o_in_stall low.
// o_in_stall stays high while the nonce is being hashed.
// Output channel: eight hash words and meets_target, presented with
// o_out_valid until taken at an edge where i_out_stall is low.
// One shared round unit and a 16-word message window run one SHA-256 round
// per cycle: 64 rounds for the header block, a feedforward and reload step,
// 64 rounds for the digest block and a step to register the result. The
// next nonce is taken only after that result is registered. The result
// register frees the core, so a new nonce is hashed while a result waits; if
// the receiver still stalls when the next result is ready, the core holds it
// and keeps o_in_stall high.
// Reset clears all configuration registers to zero and empties the block.

module double_sha256_nonce_check_unit
    import dsha_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_nonce,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_word_0,
    output logic [31:0] o_hash_word_1,
    output logic [31:0] o_hash_word_2,
    output logic [31:0] o_hash_word_3,
    output logic [31:0] o_hash_word_4,
    output logic [31:0] o_hash_word_5,
    output logic [31:0] o_hash_word_6,
    output logic [31:0] o_hash_word_7,
    output logic        o_meets_target
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_MID,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        REG_MID01 = 3'd0,
        REG_MID23 = 3'd1,
        REG_MID45 = 3'd2,
        REG_MID67 = 3'd3,
        REG_TAIL01 = 3'd4,
        REG_TAIL2 = 3'd5,
        REG_TARGET = 3'd6
    } t_reg;

    logic [63:0] r_mid01, r_mid23, r_mid45, r_mid67, r_tail01;
    t_word       r_tail2, r_target;

    t_state r_state, n_state;
    t_rnd   r_cnt, n_cnt;
    logic   r_second, n_second;
    logic   r_out_valid, n_out_valid;
    t_hash  r_out, n_out;
    logic   r_meets, n_meets;

    logic   ld;
    logic   step;
    t_block ld_block;
    t_hash  ld_init;
    t_hash  mid;
    t_hash  v;
    t_hash  sum;
    t_word  w;
    logic   in_acc;
    logic   out_free;

    dsha_msg_sched u_sched (
        .i_clk   (i_clk),
        .i_load  (ld),
        .i_block (ld_block),
        .i_step  (step),
        .o_w     (w)
    );

    dsha_round u_round (
        .i_clk   (i_clk),
        .i_load  (ld),
        .i_init  (ld_init),
        .i_step  (step),
        .i_k     (round_k(r_cnt)),
        .i_w     (w),
        .o_state (v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid01  <= '0;
            r_mid23  <= '0;
            r_mid45  <= '0;
            r_mid67  <= '0;
            r_tail01 <= '0;
            r_tail2  <= '0;
            r_target <= '0;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                REG_MID01:  r_mid01  <= i_cfg_data;
                REG_MID23:  r_mid23  <= i_cfg_data;
                REG_MID45:  r_mid45  <= i_cfg_data;
                REG_MID67:  r_mid67  <= i_cfg_data;
                REG_TAIL01: r_tail01 <= i_cfg_data;
                REG_TAIL2:  r_tail2  <= i_cfg_data[31:0];
                REG_TARGET: r_target <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        mid = {r_mid67[31:0], r_mid67[63:32], r_mid45[31:0], r_mid45[63:32],
               r_mid23[31:0], r_mid23[63:32], r_mid01[31:0], r_mid01[63:32]};
        for (int j = 0; j < NumH; j++) begin
            sum[j] = (r_second ? InitH[j] : mid[j]) + v[j];
        end
    end

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_second    = r_second;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_meets     = r_meets;
        ld          = 1'b0;
        step        = 1'b0;
        ld_block    = '0;
        ld_init     = mid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                ld_block[0]  = r_tail01[63:32];
                ld_block[1]  = r_tail01[31:0];
                ld_block[2]  = r_tail2;
                ld_block[3]  = i_nonce;
                ld_block[4]  = PadWord;
                ld_block[15] = LenHeader;
                if (in_acc) begin
                    ld       = 1'b1;
                    n_cnt    = '0;
                    n_second = 1'b0;
                    n_state  = S_RUN;
                end
            end
            S_RUN: begin
                step  = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == t_rnd'(NumRnd - 1)) begin
                    n_state = r_second ? S_DONE : S_MID;
                end
            end
            S_MID: begin
                for (int j = 0; j < NumH; j++) begin
                    ld_block[j] = sum[j];
                end
                ld_block[8]  = PadWord;
                ld_block[15] = LenDigest;
                ld_init      = InitH;
                ld           = 1'b1;
                n_second     = 1'b1;
                n_cnt        = '0;
                n_state      = S_RUN;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = sum;
                    n_meets     = sum[0] < r_target;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
        r_out   <= n_out;
        r_meets <= n_meets;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_hash_word_0  = r_out[0];
    assign o_hash_word_1  = r_out[1];
    assign o_hash_word_2  = r_out[2];
    assign o_hash_word_3  = r_out[3];
    assign o_hash_word_4  = r_out[4];
    assign o_hash_word_5  = r_out[5];
    assign o_hash_word_6  = r_out[6];
    assign o_hash_word_7  = r_out[7];
    assign o_meets_target = r_meets;

endmodule

// ----- rtl/dsha_msg_sched.sv -----
`timescale 1ns / 1ps

module dsha_msg_sched
    import dsha_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_load,
    input  t_block i_block,
    input  logic   i_step,
    output t_word  o_w
);

    t_block r_win;
    t_word  n_new;
    t_word  s0;
    t_word  s1;

    always_comb begin
        s0    = rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3);
        s1    = rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10);
        n_new = s1 + r_win[9] + s0 + r_win[0];
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_win <= i_block;
        end else if (i_step) begin
            for (int j = 0; j < NumW - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[NumW-1] <= n_new;
        end
    end

    assign o_w = r_win[0];

endmodule

// ----- rtl/dsha_round.sv -----
`timescale 1ns / 1ps

module dsha_round
    import dsha_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_load,
    input  t_hash i_init,
    input  logic  i_step,
    input  t_word i_k,
    input  t_word i_w,
    output t_hash o_state
);

    t_hash r_v;
    t_word sig0;
    t_word sig1;
    t_word ch;
    t_word maj;
    t_word t1;
    t_word t2;

    always_comb begin
        sig1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch   = r_v[6] ^ (r_v[4] & (r_v[5] ^ r_v[6]));
        t1   = r_v[7] + sig1 + ch + i_k + i_w;
        sig0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) | (r_v[2] & (r_v[0] | r_v[1]));
        t2   = sig0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_v <= i_init;
        end else if (i_step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_state = r_v;

endmodule
